// File: rtl/psca_pkg.sv
// Shared constants, field layout and types of the sound channel allocator.
package psca_pkg;

	localparam int CHANNELS     = 8;
	localparam int ORIGIN_WIDTH = 16;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int PRIO_W   = 8;
	localparam int DUR_W    = 16;
	localparam int TICK_W   = 32;
	localparam int ORG_IN_W = 16;
	localparam int CHAN_W   = 3;
	localparam int MASK_W   = 8;

	localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STOP_ORG = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_STOP_ALL = 2'd3;

	localparam logic [STATUS_W-1:0] ST_STARTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STOPPED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd3;

	localparam int IN_ORG_LO  = 0;
	localparam int IN_PK_LO   = IN_ORG_LO + ORG_IN_W;
	localparam int IN_PRI_LO  = IN_PK_LO + 1;
	localparam int IN_DUR_LO  = IN_PRI_LO + PRIO_W;
	localparam int IN_NOW_LO  = IN_DUR_LO + DUR_W;
	localparam int IN_USED_W  = IN_NOW_LO + TICK_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	localparam int OUT_USED_W  = CHAN_W + 1 + MASK_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	typedef struct packed {
		logic [ORIGIN_WIDTH-1:0] origin;
		logic                    pickup;
		logic [PRIO_W-1:0]       prio;
		logic [TICK_W-1:0]       end_tick;
	} chan_entry_t;

	typedef struct packed {
		logic org_eq;
		logic pk_eq;
		logic pri_ge;
		logic expired;
	} cmp_flags_t;

endpackage

// File: rtl/priority_sound_channel_allocator_core.sv
// Top level of the priority sound channel allocator with scan sequencer.
//
//  channel  | group            | beat contents
//  ---------+------------------+-------------------------------------------------
//  request  | s_tvalid/tready  | tuser: command; tdata: origin, pickup, prio,
//           |                  | duration, now
//  result   | m_tvalid/tready  | tuser: status; tdata: channel, evicted, freed
//
// A start scans the channel table twice and then writes it; other commands scan it once.
// s_tready returns together with m_tvalid.
// Each scan step reads one channel-table entry through the shared compare unit.
// Reset clears the busy flags and the sequencer; the table itself is not cleared.
// A finished result waits in the output register while the next request beat is taken.
// s_tready is high only while the sequencer is idle.
module priority_sound_channel_allocator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// origin_id[15:0], pickup[16], priority_req[24:17], duration[40:25], now[72:41], zero
	input  logic [psca_pkg::IN_TDATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [psca_pkg::CMD_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// channel[2:0], evicted[3], freed_mask[11:4], zero
	output logic [psca_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [psca_pkg::STATUS_W-1:0]    m_tuser
);
	import psca_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN1 = 3'd1;
	localparam logic [2:0] S_SCAN2 = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]              state_q;
	logic [CHANNELS-1:0]     busy_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic [STATUS_W-1:0]     m_tuser_q;

	logic [CMD_W-1:0]        cmd_q;
	logic [ORIGIN_WIDTH-1:0] org_q;
	logic                    pk_q;
	logic [PRIO_W-1:0]       pri_q;
	logic [TICK_W-1:0]       now_q;
	logic [TICK_W-1:0]       end_q;
	logic [CH_W-1:0]         idx_q;
	logic                    hit_q;
	logic [CH_W-1:0]         hit_idx_q;
	logic                    free_hit_q;
	logic [CH_W-1:0]         free_idx_q;
	logic                    ev_hit_q;
	logic [CH_W-1:0]         ev_idx_q;
	logic [CHANNELS-1:0]     freed_q;

	chan_entry_t             rd_entry;
	chan_entry_t             wr_entry;
	cmp_flags_t              flags;
	logic                    in_beat;
	logic                    last;
	logic                    scanning;
	logic [CH_W-1:0]         rd_idx;
	logic                    cond1;
	logic                    take1;
	logic                    slot_ok;
	logic [CH_W-1:0]         slot;
	logic                    tbl_we;
	logic                    out_free;
	logic [STATUS_W-1:0]     res_status;
	logic [CH_W-1:0]         res_chan;
	logic                    res_evicted;

	assign s_tready = (state_q == S_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign last     = (idx_q == CH_W'(CHANNELS - 1));
	assign scanning = (state_q == S_SCAN1) || (state_q == S_SCAN2);
	assign rd_idx   = (scanning && !last) ? idx_q + 1'b1 : '0;

	psca_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (slot),
		.wdata (wr_entry),
		.raddr (rd_idx),
		.rdata (rd_entry)
	);

	psca_cmp u_cmp (
		.entry      (rd_entry),
		.req_origin (org_q),
		.req_pickup (pk_q),
		.req_prio   (pri_q),
		.now        (now_q),
		.flags      (flags)
	);

	always_comb begin
		case (cmd_q)
			CMD_START:    cond1 = flags.org_eq && flags.pk_eq;
			CMD_STOP_ORG: cond1 = flags.org_eq;
			CMD_TICK:     cond1 = flags.expired;
			default:      cond1 = 1'b1;
		endcase
		cond1 = cond1 && busy_q[idx_q];
		take1 = cond1 && ((cmd_q == CMD_TICK) || (cmd_q == CMD_STOP_ALL) || !hit_q);
	end

	assign slot_ok = free_hit_q || ev_hit_q;
	assign slot    = free_hit_q ? free_idx_q : ev_idx_q;
	assign tbl_we  = (state_q == S_WRITE) && slot_ok;

	always_comb begin
		wr_entry.origin   = org_q;
		wr_entry.pickup   = pk_q;
		wr_entry.prio     = pri_q;
		wr_entry.end_tick = end_q;
	end

	always_comb begin
		if (cmd_q == CMD_START) begin
			res_status  = slot_ok ? ST_STARTED : ST_REJECTED;
			res_chan    = slot_ok ? slot : '0;
			res_evicted = !free_hit_q && ev_hit_q;
		end else begin
			res_status  = hit_q ? ST_STOPPED : ST_NOTHING;
			res_chan    = hit_q ? hit_idx_q : '0;
			res_evicted = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			busy_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_SCAN1;
					end
				end
				S_SCAN1: begin
					if (take1) begin
						busy_q[idx_q] <= 1'b0;
					end
					if (last) begin
						state_q <= (cmd_q == CMD_START) ? S_SCAN2 : S_DONE;
					end
				end
				S_SCAN2: begin
					if (last) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (slot_ok) begin
						busy_q[slot] <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					cmd_q      <= s_tuser;
					org_q      <= ORIGIN_WIDTH'(s_tdata[IN_ORG_LO +: ORG_IN_W]);
					pk_q       <= s_tdata[IN_PK_LO];
					pri_q      <= s_tdata[IN_PRI_LO +: PRIO_W];
					now_q      <= s_tdata[IN_NOW_LO +: TICK_W];
					end_q      <= s_tdata[IN_NOW_LO +: TICK_W]
						+ TICK_W'(s_tdata[IN_DUR_LO +: DUR_W]);
					idx_q      <= '0;
					hit_q      <= 1'b0;
					free_hit_q <= 1'b0;
					ev_hit_q   <= 1'b0;
					freed_q    <= '0;
				end
			end
			S_SCAN1: begin
				if (take1) begin
					freed_q[idx_q] <= 1'b1;
					if (!hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
				end
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
			S_SCAN2: begin
				if (!busy_q[idx_q] && !free_hit_q) begin
					free_hit_q <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (flags.pri_ge && !ev_hit_q) begin
					ev_hit_q <= 1'b1;
					ev_idx_q <= idx_q;
				end
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
			S_WRITE: begin
				if (!free_hit_q && ev_hit_q) begin
					freed_q[ev_idx_q] <= 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tuser_q <= res_status;
					m_tdata_q <= OUT_TDATA_W'({MASK_W'(freed_q), res_evicted, CHAN_W'(res_chan)});
				end
			end
			default: begin
				idx_q <= '0;
			end
		endcase
	end

endmodule

// File: rtl/psca_cmp.sv
// Shared compare unit: matches one channel entry against the request under scan.
module psca_cmp (
	input  psca_pkg::chan_entry_t             entry,
	input  logic [psca_pkg::ORIGIN_WIDTH-1:0] req_origin,
	input  logic                              req_pickup,
	input  logic [psca_pkg::PRIO_W-1:0]       req_prio,
	input  logic [psca_pkg::TICK_W-1:0]       now,
	output psca_pkg::cmp_flags_t              flags
);
	import psca_pkg::*;

	always_comb begin
		flags.org_eq  = (entry.origin == req_origin);
		flags.pk_eq   = (entry.pickup == req_pickup);
		flags.pri_ge  = (entry.prio >= req_prio);
		flags.expired = (entry.end_tick < now);
	end

endmodule

// File: rtl/psca_table.sv
// Channel table: origin, pickup class, priority and end tick of each channel.
module psca_table (
	input  logic                      clk,
	input  logic                      we,
	input  logic [psca_pkg::CH_W-1:0] waddr,
	input  psca_pkg::chan_entry_t     wdata,
	input  logic [psca_pkg::CH_W-1:0] raddr,
	output psca_pkg::chan_entry_t     rdata
);
	import psca_pkg::*;

	chan_entry_t entry_q [CHANNELS];
	chan_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q[waddr] <= wdata;
		end
		rdata_q <= entry_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/psca_chk.sv
// Port checker for the sound channel allocator, bound to the top level.
module psca_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [psca_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [psca_pkg::STATUS_W-1:0]    m_tuser
);
	import psca_pkg::*;

	localparam int EV_BIT = CHAN_W;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous beat in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result beat changed");

	a_nothing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_NOTHING)) |-> (m_tdata[OUT_USED_W-1:0] == '0))
		else $error("nothing-done result carries channel or freed bits");

	a_evict_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[EV_BIT]) |-> (m_tuser == ST_STARTED))
		else $error("eviction flagged on a result that did not start");

endmodule

bind priority_sound_channel_allocator_core psca_chk u_psca_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
